### hdl/ordered_array_list_defines.svh
// Assertion macros used by the checker file of the ordered array list.
`ifndef ORDERED_ARRAY_LIST_DEFINES_SVH
`define ORDERED_ARRAY_LIST_DEFINES_SVH

// Check a same-cycle implication on the rising clock edge, idle during reset.
`define OAL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check a next-cycle implication on the rising clock edge, idle during reset.
`define OAL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### hdl/oal_pkg.sv
// Shared types and constants of the ordered array list.
package oal_pkg;

    localparam int unsigned CAPACITY_DEF = 16;
    localparam int unsigned OP_W         = 3;
    localparam int unsigned POS_W        = 4;
    localparam int unsigned DATA_W       = 32;
    localparam int unsigned STAT_W       = 3;
    localparam int unsigned CNT_W        = 5;

    typedef enum logic [OP_W-1:0] {
        OP_INS_AT    = 3'd0,
        OP_INS_FRONT = 3'd1,
        OP_INS_END   = 3'd2,
        OP_DEL_AT    = 3'd3,
        OP_DEL_FRONT = 3'd4,
        OP_DEL_END   = 3'd5,
        OP_SEARCH    = 3'd6,
        OP_READ      = 3'd7
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_RANGE    = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        MODE_HOLD = 2'd0,
        MODE_INS  = 2'd1,
        MODE_DEL  = 2'd2
    } t_mode;

    // Control broadcast from the sequencer to every cell of the chain
    typedef struct packed {
        t_mode              mode;
        logic [DATA_W-1:0]  value;
    } t_cell_ctl;

endpackage

### hdl/oal_cmd_if.sv
// Command channel of the ordered array list.
interface oal_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [oal_pkg::OP_W-1:0]       op;
    logic [oal_pkg::POS_W-1:0]      position;
    logic signed [oal_pkg::DATA_W-1:0] value;

    modport source (output valid, output op, output position, output value, input ready);
    modport sink (input valid, input op, input position, input value, output ready);
endinterface

### hdl/oal_res_if.sv
// Result channel of the ordered array list.
interface oal_res_if;
    logic                              valid;
    logic                              ready;
    logic [oal_pkg::STAT_W-1:0]        status;
    logic signed [oal_pkg::DATA_W-1:0] data;
    logic [oal_pkg::POS_W-1:0]         found_index;
    logic [oal_pkg::CNT_W-1:0]         entry_count;

    modport source (output valid, output status, output data, output found_index,
                    output entry_count, input ready);
    modport sink (input valid, input status, input data, input found_index,
                  input entry_count, output ready);
endinterface

### hdl/ordered_array_list.sv
// Ordered array list: command sequencer over a chain of shifting storage cells.
//
// Usage:
//   i_cmd carries one command word (op, position, value) per valid/ready
//   handshake; o_res returns exactly one result word (status, data,
//   found_index, entry_count) per command, in command order.
//   Execution: an accepted command is latched and moves the sequencer to
//   S_EXEC; the execute step then runs the command and loads the output
//   register, which drives the result word.
//   Steps: the sequencer takes no new command until the pending one has
//   executed. A command is first accepted, then executed: all cells shift
//   or compare in parallel and the lowest matching cell is priority encoded.
//   Stall: the execute step waits while the output register still holds an
//   untaken word; i_cmd.ready stays low until the pending command executes.
//   Reset: synchronous, active low; clears the entry count, the sequencer
//   and the output valid. Cell contents are not cleared; only entries below
//   the count are ever returned.
module ordered_array_list #(
    parameter int unsigned CAPACITY = oal_pkg::CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    oal_cmd_if.sink   i_cmd,
    oal_res_if.source o_res
);

    localparam int unsigned CW    = $clog2(CAPACITY + 1);
    localparam int unsigned AW    = $clog2(CAPACITY);
    localparam int unsigned AT_W  = (CW > oal_pkg::POS_W) ? CW : oal_pkg::POS_W;
    localparam int unsigned EXT_W = (CW > oal_pkg::CNT_W) ? CW : oal_pkg::CNT_W;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state                         r_state;
    oal_pkg::t_op                   r_op;
    logic [AT_W-1:0]                r_at;
    logic [oal_pkg::DATA_W-1:0]     r_value;
    logic [CW-1:0]                  r_count;
    logic                           r_out_valid;
    oal_pkg::t_status               r_status;
    logic [oal_pkg::DATA_W-1:0]     r_data;
    logic [oal_pkg::POS_W-1:0]      r_found;
    logic [oal_pkg::CNT_W-1:0]      r_cnt_out;

    oal_pkg::t_status               n_status;
    logic [oal_pkg::DATA_W-1:0]     n_data;
    logic [oal_pkg::POS_W-1:0]      n_found;
    logic [CW-1:0]                  n_count;
    logic [AT_W-1:0]                n_at;

    logic                           w_fire_in;
    logic                           w_commit;
    oal_pkg::t_op                   w_in_op;
    oal_pkg::t_mode                 w_mode;
    oal_pkg::t_cell_ctl             w_ctl;
    logic [CAPACITY-1:0]            w_ge;
    logic [CAPACITY-1:0]            w_live;
    logic [CAPACITY-1:0]            w_match;
    logic [oal_pkg::DATA_W-1:0]     w_val [CAPACITY];
    logic                           w_full;
    logic                           w_empty;
    logic                           w_at_gt;
    logic                           w_at_ge;
    logic [oal_pkg::DATA_W-1:0]     w_entry;
    logic                           w_any;
    logic [AW-1:0]                  w_first;
    logic [AT_W-1:0]                w_first_ext;
    logic [EXT_W-1:0]               w_cnt_ext;

    // Handshakes
    assign i_cmd.ready = (r_state == S_IDLE);
    assign w_fire_in   = i_cmd.valid && i_cmd.ready;
    assign w_commit    = (r_state == S_EXEC) && (!r_out_valid || o_res.ready);
    assign w_in_op     = oal_pkg::t_op'(i_cmd.op);

    // Resolve the target index of an incoming command
    always_comb begin
        case (w_in_op)
            oal_pkg::OP_INS_AT,
            oal_pkg::OP_DEL_AT,
            oal_pkg::OP_READ:      n_at = AT_W'(i_cmd.position);
            oal_pkg::OP_INS_END:   n_at = AT_W'(r_count);
            oal_pkg::OP_DEL_END:   n_at = AT_W'(r_count) - AT_W'(1);
            default:               n_at = '0;
        endcase
    end

    // List condition flags against the latched target
    assign w_full  = (r_count == CW'(CAPACITY));
    assign w_empty = (r_count == '0);
    assign w_at_gt = (r_at > AT_W'(r_count));
    assign w_at_ge = (r_at >= AT_W'(r_count));
    assign w_entry = w_val[r_at[AW-1:0]];

    // Find the lowest live cell that matches the key
    always_comb begin
        w_any   = 1'b0;
        w_first = '0;
        for (int k = CAPACITY - 1; k >= 0; k--) begin
            if (w_match[k]) begin
                w_any   = 1'b1;
                w_first = AW'(k);
            end
        end
    end
    assign w_first_ext = AT_W'(w_first);

    // Decide status, returned word, new count and cell action
    always_comb begin
        n_status = oal_pkg::ST_OK;
        n_data   = '0;
        n_found  = '0;
        n_count  = r_count;
        w_mode   = oal_pkg::MODE_HOLD;
        case (r_op)
            oal_pkg::OP_INS_AT,
            oal_pkg::OP_INS_FRONT,
            oal_pkg::OP_INS_END: begin
                if (w_full) begin
                    n_status = oal_pkg::ST_FULL;
                end else if (w_at_gt) begin
                    n_status = oal_pkg::ST_RANGE;
                end else begin
                    n_count = r_count + CW'(1);
                    w_mode  = oal_pkg::MODE_INS;
                end
            end
            oal_pkg::OP_DEL_AT,
            oal_pkg::OP_DEL_FRONT,
            oal_pkg::OP_DEL_END: begin
                if (w_empty) begin
                    n_status = oal_pkg::ST_EMPTY;
                end else if (w_at_ge) begin
                    n_status = oal_pkg::ST_RANGE;
                end else begin
                    n_data  = w_entry;
                    n_count = r_count - CW'(1);
                    w_mode  = oal_pkg::MODE_DEL;
                end
            end
            oal_pkg::OP_SEARCH: begin
                if (w_any) begin
                    n_found = w_first_ext[oal_pkg::POS_W-1:0];
                end else begin
                    n_status = oal_pkg::ST_NOTFOUND;
                end
            end
            default: begin
                if (w_empty) begin
                    n_status = oal_pkg::ST_EMPTY;
                end else if (w_at_ge) begin
                    n_status = oal_pkg::ST_RANGE;
                end else begin
                    n_data = w_entry;
                end
            end
        endcase
    end
    assign w_cnt_ext = EXT_W'(n_count);

    // Broadcast the cell action only in the commit cycle
    assign w_ctl.mode  = w_commit ? w_mode : oal_pkg::MODE_HOLD;
    assign w_ctl.value = r_value;

    // Chain of storage cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign w_ge[g]   = (AT_W'(g) >= r_at);
        assign w_live[g] = (CW'(g) < r_count);

        if (g == 0) begin : g_head
            oal_cell u_cell (
                .i_clk     (i_clk),
                .i_ctl     (w_ctl),
                .i_ge      (w_ge[g]),
                .i_ge_left (1'b0),
                .i_live    (w_live[g]),
                .i_left    (w_val[g]),
                .i_right   (w_val[(g + 1 < CAPACITY) ? g + 1 : g]),
                .o_val     (w_val[g]),
                .o_match   (w_match[g])
            );
        end else begin : g_body
            oal_cell u_cell (
                .i_clk     (i_clk),
                .i_ctl     (w_ctl),
                .i_ge      (w_ge[g]),
                .i_ge_left (w_ge[g-1]),
                .i_live    (w_live[g]),
                .i_left    (w_val[g-1]),
                .i_right   (w_val[(g + 1 < CAPACITY) ? g + 1 : g]),
                .o_val     (w_val[g]),
                .o_match   (w_match[g])
            );
        end
    end

    // Sequencer state, latched command, count and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Raise valid on commit, drop it once the word is taken
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_fire_in) begin
                        r_op    <= w_in_op;
                        r_at    <= n_at;
                        r_value <= i_cmd.value;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_commit) begin
                        r_count     <= n_count;
                        r_status    <= n_status;
                        r_data      <= n_data;
                        r_found     <= n_found;
                        r_cnt_out   <= w_cnt_ext[oal_pkg::CNT_W-1:0];
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Drive the result channel
    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_status;
    assign o_res.data        = r_data;
    assign o_res.found_index = r_found;
    assign o_res.entry_count = r_cnt_out;

endmodule

### hdl/oal_cell.sv
// One storage cell of the list chain: holds an entry, shifts with its neighbors.
module oal_cell (
    input  logic                          i_clk,
    input  oal_pkg::t_cell_ctl            i_ctl,
    input  logic                          i_ge,
    input  logic                          i_ge_left,
    input  logic                          i_live,
    input  logic [oal_pkg::DATA_W-1:0]    i_left,
    input  logic [oal_pkg::DATA_W-1:0]    i_right,
    output logic [oal_pkg::DATA_W-1:0]    o_val,
    output logic                          o_match
);

    logic [oal_pkg::DATA_W-1:0] r_val;
    logic [oal_pkg::DATA_W-1:0] n_val;

    // Insert takes left above gap, new at gap; delete takes right; else hold
    always_comb begin
        n_val = r_val;
        case (i_ctl.mode)
            oal_pkg::MODE_INS: begin
                if (i_ge) begin
                    n_val = i_ge_left ? i_left : i_ctl.value;
                end
            end
            oal_pkg::MODE_DEL: begin
                if (i_ge) begin
                    n_val = i_right;
                end
            end
            default: begin
                n_val = r_val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    // Compare the held word against the broadcast search key
    assign o_match = i_live && (r_val == i_ctl.value);
    assign o_val   = r_val;

endmodule

### hdl/oal_checker.sv
// Port-level assertion checker of the ordered array list, with its bind.
`include "ordered_array_list_defines.svh"

module oal_checker #(
    parameter int unsigned CAPACITY = oal_pkg::CAPACITY_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_cmd_valid,
    input logic                          i_cmd_ready,
    input logic                          i_res_valid,
    input logic                          i_res_ready,
    input logic [oal_pkg::STAT_W-1:0]    i_res_status,
    input logic [oal_pkg::CNT_W-1:0]     i_res_entry_count
);

    logic w_cmd_fire;
    logic w_res_fire;
    logic w_is_full;
    logic w_is_empty;

    assign w_cmd_fire = i_cmd_valid && i_cmd_ready;
    assign w_res_fire = i_res_valid && i_res_ready;
    assign w_is_full  = i_res_valid && (i_res_status == oal_pkg::ST_FULL);
    assign w_is_empty = i_res_valid && (i_res_status == oal_pkg::ST_EMPTY);

    // Hold a result word until it is taken
    `OAL_ASSERT_NEXT(a_res_hold, i_res_valid && !i_res_ready, i_res_valid, "result dropped")
    // Block new commands while one is pending
    `OAL_ASSERT_NEXT(a_one_pending, w_cmd_fire, !i_cmd_ready, "second command taken")
    // Deliver the result without a stall after acceptance into an empty or draining output
    `OAL_ASSERT_NEXT(a_latency, w_cmd_fire && (!i_res_valid || w_res_fire),
        ##1 i_res_valid, "result late")
    // Report full only at capacity, empty only at zero
    `OAL_ASSERT_NOW(a_full_cnt, w_is_full,
        i_res_entry_count == oal_pkg::CNT_W'(CAPACITY), "full status with wrong count")
    `OAL_ASSERT_NOW(a_empty_cnt, w_is_empty, i_res_entry_count == '0,
        "empty status with nonzero count")

endmodule

bind ordered_array_list oal_checker #(.CAPACITY(CAPACITY)) u_oal_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_cmd_valid       (i_cmd.valid),
    .i_cmd_ready       (i_cmd.ready),
    .i_res_valid       (o_res.valid),
    .i_res_ready       (o_res.ready),
    .i_res_status      (o_res.status),
    .i_res_entry_count (o_res.entry_count)
);
